@@ sv/mrpm_pkg.sv @@
// ----------------------------------------------------------------------------
// mrpm_pkg
// shared constants and types of the modbus rtu polling master
// ----------------------------------------------------------------------------
`default_nettype none

package mrpm_pkg;

    localparam int RESPONSE_BYTES = 9;
    localparam int REQUEST_BYTES  = 8;
    localparam int NUM_QUANTITIES = 6;
    localparam int NUM_REG_ADDRS  = 6;

    localparam int QTY_W   = 3;
    localparam int CNT_W   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // frame constants
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
    localparam logic [15:0] REG_COUNT       = 16'h0002;

    // no previous request yet
    localparam logic [QTY_W-1:0] PREV_NONE = 3'd7;

    // input commands
    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_RX_BYTE = 1'b1;

    // result kinds
    localparam logic KIND_TX_BYTE = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_ADDR_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_ADDR_LAST  = 3'd6;

    // request byte positions
    localparam logic [2:0] REQ_POS_SLAVE   = 3'd0;
    localparam logic [2:0] REQ_POS_FUNC    = 3'd1;
    localparam logic [2:0] REQ_POS_ADDR_HI = 3'd2;
    localparam logic [2:0] REQ_POS_ADDR_LO = 3'd3;
    localparam logic [2:0] REQ_POS_CNT_HI  = 3'd4;
    localparam logic [2:0] REQ_POS_CNT_LO  = 3'd5;
    localparam logic [2:0] REQ_POS_CRC_LO  = 3'd6;
    localparam logic [2:0] REQ_POS_CRC_HI  = 3'd7;

    // control of the shared crc unit
    typedef struct packed {
        logic       init;
        logic       step;
        logic [7:0] data;
    } crc_ctrl_t;

endpackage

`default_nettype wire

@@ sv/mrpm_if.sv @@
// ----------------------------------------------------------------------------
// mrpm channel interfaces
// valid/ready channels for input items, result items and config writes
// ----------------------------------------------------------------------------
`default_nettype none

interface mrpm_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface mrpm_out_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [7:0]                  tx_byte;
    logic                        last;
    logic [mrpm_pkg::QTY_W-1:0]  quantity;
    logic [31:0]                 value_bits;
    logic                        crc_ok;
    logic                        comm_error;

    modport source (output valid, output kind, output tx_byte, output last,
                    output quantity, output value_bits, output crc_ok,
                    output comm_error, input ready);
    modport sink   (input valid, input kind, input tx_byte, input last,
                    input quantity, input value_bits, input crc_ok,
                    input comm_error, output ready);
endinterface

interface mrpm_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mrpm_pkg::CFG_IDX_W-1:0]   index;
    logic [mrpm_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/mrpm_crc_unit.sv @@
// ----------------------------------------------------------------------------
// mrpm_crc_unit
// modbus crc-16 accumulator, one byte folded in per step
// ----------------------------------------------------------------------------
`default_nettype none

module mrpm_crc_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mrpm_pkg::crc_ctrl_t ctrl,
    output logic [15:0]             crc
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    // eight reflected shift steps over one byte
    always_comb
    begin
        crc_next = crc_reg ^ {8'h00, ctrl.data};
        for (int b = 0; b < 8; b++)
        begin
            if (crc_next[0])
                crc_next = (crc_next >> 1) ^ mrpm_pkg::CRC_POLY;
            else
                crc_next = crc_next >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= mrpm_pkg::CRC_INIT;
        else if (ctrl.init)
            crc_reg <= mrpm_pkg::CRC_INIT;
        else if (ctrl.step)
            crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule

`default_nettype wire

@@ sv/modbus_rtu_polling_master.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_polling_master
// modbus rtu master polling six meter quantities with read input registers
// ----------------------------------------------------------------------------
// A request beat (command 0) produces eight transmit beats: slave address,
// function 0x04, the current quantity's register address high byte first,
// count 0x0002 and the crc-16 low byte first; last marks the eighth. The
// error flag goes high when the same quantity is requested twice without a
// good answer in between. A receive beat (command 1) stores one byte; the
// ninth byte closes the frame and gives one report beat with bytes 3..6 as
// big-endian value bits and crc_ok; a good crc clears the error flag and
// moves on to the next quantity. One crc unit folds in one byte per clock:
// a request first hashes its six header bytes and then sends its eight
// transmit beats as the output register frees; the ninth receive byte
// first hashes the seven bytes before the received crc, then posts the
// report. Input ready is low while a frame is worked on; the output
// register lets the last beat wait while the next input beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_polling_master (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mrpm_in_if.sink     item,
    mrpm_out_if.source  result,
    mrpm_cfg_if.sink    cfg
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REQ_CRC,
        ST_REQ_SEND,
        ST_RSP_CRC,
        ST_RSP_SEND
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [7:0]  slave_address_reg;
    logic [15:0] reg_addr_reg [mrpm_pkg::NUM_REG_ADDRS];

    // frame store, undefined until written
    logic [7:0]  frame_store [mrpm_pkg::RESPONSE_BYTES];

    logic [mrpm_pkg::CNT_W-1:0] byte_count_reg;
    logic [mrpm_pkg::CNT_W-1:0] step_reg;
    logic [mrpm_pkg::QTY_W-1:0] quantity_reg;
    logic [mrpm_pkg::QTY_W-1:0] previous_reg;
    logic                       error_reg;

    // output register
    logic                       out_valid_reg;
    logic                       out_kind_reg;
    logic [7:0]                 out_tx_reg;
    logic                       out_last_reg;
    logic [mrpm_pkg::QTY_W-1:0] out_qty_reg;
    logic [31:0]                out_value_reg;
    logic                       out_ok_reg;
    logic                       out_err_reg;

    mrpm_pkg::crc_ctrl_t crc_ctrl;
    logic [15:0]         crc;

    logic        in_beat;
    logic        slot_free;
    logic        out_load;
    logic [15:0] addr_sel;
    logic [7:0]  req_byte;
    logic [2:0]  req_pos;
    logic [15:0] frame_crc;
    logic        crc_match;
    logic [mrpm_pkg::CNT_W-1:0] qty_inc;
    logic [mrpm_pkg::QTY_W-1:0] qty_next;

    assign item.ready = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;
    assign in_beat    = item.valid && item.ready;
    assign slot_free  = !out_valid_reg || result.ready;

    // a new beat goes into the output register this clock
    assign out_load   = slot_free &&
                        (state_reg == ST_REQ_SEND || state_reg == ST_RSP_SEND);

    // register address of the current quantity, zero when it has none
    always_comb
    begin
        if ({1'b0, quantity_reg} < mrpm_pkg::CNT_W'(mrpm_pkg::NUM_REG_ADDRS))
            addr_sel = reg_addr_reg[quantity_reg];
        else
            addr_sel = 16'h0000;
    end

    assign req_pos = step_reg[2:0];

    // request frame byte at the current position
    always_comb
    begin
        unique case (req_pos)
            mrpm_pkg::REQ_POS_SLAVE:   req_byte = slave_address_reg;
            mrpm_pkg::REQ_POS_FUNC:    req_byte = mrpm_pkg::FUNC_READ_INPUT;
            mrpm_pkg::REQ_POS_ADDR_HI: req_byte = addr_sel[15:8];
            mrpm_pkg::REQ_POS_ADDR_LO: req_byte = addr_sel[7:0];
            mrpm_pkg::REQ_POS_CNT_HI:  req_byte = mrpm_pkg::REG_COUNT[15:8];
            mrpm_pkg::REQ_POS_CNT_LO:  req_byte = mrpm_pkg::REG_COUNT[7:0];
            mrpm_pkg::REQ_POS_CRC_LO:  req_byte = crc[7:0];
            mrpm_pkg::REQ_POS_CRC_HI:  req_byte = crc[15:8];
            default:                   req_byte = 8'h00;
        endcase
    end

    // received crc is the last two bytes, low first
    assign frame_crc = {frame_store[mrpm_pkg::RESPONSE_BYTES-1],
                        frame_store[mrpm_pkg::RESPONSE_BYTES-2]};
    assign crc_match = (crc == frame_crc);

    // cyclic advance of the quantity index
    assign qty_inc  = {1'b0, quantity_reg} + mrpm_pkg::CNT_W'(1);
    assign qty_next = (qty_inc >= mrpm_pkg::CNT_W'(mrpm_pkg::NUM_QUANTITIES))
                      ? '0 : qty_inc[mrpm_pkg::QTY_W-1:0];

    // crc unit control: clear on each input beat, hash one byte per clock
    always_comb
    begin
        crc_ctrl.init = 1'b0;
        crc_ctrl.step = 1'b0;
        crc_ctrl.data = 8'h00;
        unique case (state_reg)
            ST_IDLE:
            begin
                crc_ctrl.init = in_beat;
            end
            ST_REQ_CRC:
            begin
                crc_ctrl.step = 1'b1;
                crc_ctrl.data = req_byte;
            end
            ST_RSP_CRC:
            begin
                crc_ctrl.step = 1'b1;
                crc_ctrl.data = frame_store[step_reg];
            end
            ST_REQ_SEND, ST_RSP_SEND:
            begin
                crc_ctrl.init = 1'b0;
            end
            default:
            begin
                crc_ctrl.init = 1'b0;
            end
        endcase
    end

    mrpm_crc_unit u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (crc_ctrl),
        .crc   (crc)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= 8'h01;
            for (int i = 0; i < mrpm_pkg::NUM_REG_ADDRS; i++)
                reg_addr_reg[i] <= 16'h0000;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == mrpm_pkg::CFG_SLAVE_ADDRESS)
                slave_address_reg <= cfg.data[7:0];
            else if (cfg.index >= mrpm_pkg::CFG_REG_ADDR_FIRST &&
                     cfg.index <= mrpm_pkg::CFG_REG_ADDR_LAST)
                reg_addr_reg[cfg.index - mrpm_pkg::CFG_REG_ADDR_FIRST] <= cfg.data;
        end
    end

    // frame store, written one received byte at a time
    always_ff @(posedge clk)
    begin
        if (in_beat && item.command == mrpm_pkg::CMD_RX_BYTE)
            frame_store[byte_count_reg] <= item.rx_byte;
    end

    // sequencer with the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            byte_count_reg <= '0;
            step_reg       <= '0;
            quantity_reg   <= '0;
            previous_reg   <= mrpm_pkg::PREV_NONE;
            error_reg      <= 1'b1;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= mrpm_pkg::KIND_TX_BYTE;
            out_tx_reg     <= 8'h00;
            out_last_reg   <= 1'b0;
            out_qty_reg    <= '0;
            out_value_reg  <= 32'h0;
            out_ok_reg     <= 1'b0;
            out_err_reg    <= 1'b0;
        end
        else
        begin
            if (result.ready && !out_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        step_reg <= '0;
                        if (item.command == mrpm_pkg::CMD_REQUEST)
                        begin
                            error_reg    <= (previous_reg == quantity_reg);
                            previous_reg <= quantity_reg;
                            state_reg    <= ST_REQ_CRC;
                        end
                        else if (byte_count_reg ==
                                 mrpm_pkg::CNT_W'(mrpm_pkg::RESPONSE_BYTES - 1))
                        begin
                            byte_count_reg <= '0;
                            state_reg      <= ST_RSP_CRC;
                        end
                        else
                        begin
                            byte_count_reg <= byte_count_reg + mrpm_pkg::CNT_W'(1);
                        end
                    end
                end

                ST_REQ_CRC:
                begin
                    // crc covers the six header bytes
                    if (step_reg == mrpm_pkg::CNT_W'(mrpm_pkg::REQUEST_BYTES - 3))
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_REQ_SEND;
                    end
                    else
                        step_reg <= step_reg + mrpm_pkg::CNT_W'(1);
                end

                ST_REQ_SEND:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= mrpm_pkg::KIND_TX_BYTE;
                        out_tx_reg    <= req_byte;
                        out_last_reg  <= (step_reg ==
                                          mrpm_pkg::CNT_W'(mrpm_pkg::REQUEST_BYTES - 1));
                        out_qty_reg   <= quantity_reg;
                        out_value_reg <= 32'h0;
                        out_ok_reg    <= 1'b0;
                        out_err_reg   <= error_reg;
                        if (step_reg == mrpm_pkg::CNT_W'(mrpm_pkg::REQUEST_BYTES - 1))
                        begin
                            step_reg  <= '0;
                            state_reg <= ST_IDLE;
                        end
                        else
                            step_reg <= step_reg + mrpm_pkg::CNT_W'(1);
                    end
                end

                ST_RSP_CRC:
                begin
                    // crc covers all but the two trailing crc bytes
                    if (step_reg == mrpm_pkg::CNT_W'(mrpm_pkg::RESPONSE_BYTES - 3))
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_RSP_SEND;
                    end
                    else
                        step_reg <= step_reg + mrpm_pkg::CNT_W'(1);
                end

                ST_RSP_SEND:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= mrpm_pkg::KIND_REPORT;
                        out_tx_reg    <= 8'h00;
                        out_last_reg  <= 1'b0;
                        out_qty_reg   <= quantity_reg;
                        out_value_reg <= {frame_store[3], frame_store[4],
                                          frame_store[5], frame_store[6]};
                        out_ok_reg    <= crc_match;
                        out_err_reg   <= !crc_match;
                        error_reg     <= !crc_match;
                        if (crc_match)
                            quantity_reg <= qty_next;
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.kind       = out_kind_reg;
    assign result.tx_byte    = out_tx_reg;
    assign result.last       = out_last_reg;
    assign result.quantity   = out_qty_reg;
    assign result.value_bits = out_value_reg;
    assign result.crc_ok     = out_ok_reg;
    assign result.comm_error = out_err_reg;

endmodule

`default_nettype wire

@@ tb/mrpm_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// mrpm_tb_pkg
// crc and result beat type shared by the polling master testbench
// ----------------------------------------------------------------------------
package mrpm_tb_pkg;

    import mrpm_pkg::*;

    typedef logic [7:0] frame_bytes_t [RESPONSE_BYTES];

    // one result beat as seen on the output channel
    typedef struct packed {
        logic             kind;
        logic [7:0]       tx_byte;
        logic             last;
        logic [QTY_W-1:0] quantity;
        logic [31:0]      value_bits;
        logic             crc_ok;
        logic             comm_error;
    } meter_beat_t;

    // modbus crc-16 over the first len bytes, reflected polynomial
    function automatic logic [15:0] modbus_crc16(input frame_bytes_t bytes_in, input int len);
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int i = 0; i < len; i++)
        begin
            crc = crc ^ {8'h00, bytes_in[i]};
            for (int b = 0; b < 8; b++)
            begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        return crc;
    endfunction

endpackage

@@ tb/mrpm_poll_checker.sv @@
// ----------------------------------------------------------------------------
// mrpm_poll_checker
// watches the channels, predicts request and report beats, compares them
// ----------------------------------------------------------------------------
module mrpm_poll_checker (
    input  logic clk,
    input  logic rst_n,
    mrpm_in_if   item,
    mrpm_out_if  result,
    mrpm_cfg_if  cfg,
    output int   fail_count,
    output int   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import mrpm_pkg::*;
    import mrpm_tb_pkg::*;

    localparam int SHOWN_MAX = 10;

    logic [7:0]       slave_addr;
    logic [15:0]      reg_addr [NUM_REG_ADDRS];
    frame_bytes_t     rx_frame;
    logic [CNT_W-1:0] rx_count;
    logic [QTY_W-1:0] qty_idx;
    logic [QTY_W-1:0] prev_idx;
    logic             err_flag;
    meter_beat_t      expected_beats [$];
    int               shown;

    // request beat: eight transmit beats of the read-input-registers frame
    function automatic void predict_request();
        frame_bytes_t req;
        logic [15:0]  addr;
        logic [15:0]  crc;
        meter_beat_t  beat;
        req = '{default: 8'h00};
        addr = (qty_idx < NUM_REG_ADDRS) ? reg_addr[qty_idx] : 16'h0000;
        req[REQ_POS_SLAVE]   = slave_addr;
        req[REQ_POS_FUNC]    = FUNC_READ_INPUT;
        req[REQ_POS_ADDR_HI] = addr[15:8];
        req[REQ_POS_ADDR_LO] = addr[7:0];
        req[REQ_POS_CNT_HI]  = REG_COUNT[15:8];
        req[REQ_POS_CNT_LO]  = REG_COUNT[7:0];
        crc = modbus_crc16(req, int'(REQ_POS_CRC_LO));
        req[REQ_POS_CRC_LO]  = crc[7:0];
        req[REQ_POS_CRC_HI]  = crc[15:8];
        err_flag = (prev_idx == qty_idx);
        prev_idx = qty_idx;
        for (int i = 0; i < REQUEST_BYTES; i++)
        begin
            beat = '{kind: KIND_TX_BYTE, tx_byte: req[i], last: (i == REQUEST_BYTES - 1),
                     quantity: qty_idx, value_bits: 32'h0, crc_ok: 1'b0,
                     comm_error: err_flag};
            expected_beats.push_back(beat);
        end
    endfunction

    // receive beat: the ninth byte of a frame closes it with a report
    function automatic void predict_rx(input logic [7:0] rx);
        logic [15:0] calc;
        logic        ok;
        meter_beat_t beat;
        if (rx_count >= RESPONSE_BYTES)
            rx_count = '0;
        rx_frame[rx_count] = rx;
        rx_count++;
        if (rx_count < RESPONSE_BYTES)
            return;
        calc = modbus_crc16(rx_frame, RESPONSE_BYTES - 2);
        ok = (calc == {rx_frame[RESPONSE_BYTES - 1], rx_frame[RESPONSE_BYTES - 2]});
        beat = '{kind: KIND_REPORT, tx_byte: 8'h00, last: 1'b0, quantity: qty_idx,
                 value_bits: {rx_frame[3], rx_frame[4], rx_frame[5], rx_frame[6]},
                 crc_ok: ok, comm_error: 1'b0};
        rx_count = '0;
        if (ok)
        begin
            err_flag = 1'b0;
            qty_idx = (qty_idx + 1 >= NUM_QUANTITIES) ? '0 : qty_idx + 1'b1;
        end
        else
        begin
            err_flag = 1'b1;
        end
        beat.comm_error = err_flag;
        expected_beats.push_back(beat);
    endfunction

    function automatic void check_result();
        meter_beat_t got;
        meter_beat_t want;
        got = '{kind: result.kind, tx_byte: result.tx_byte, last: result.last,
                quantity: result.quantity, value_bits: result.value_bits,
                crc_ok: result.crc_ok, comm_error: result.comm_error};
        if (expected_beats.size() == 0)
        begin
            fail_count++;
            if (shown < SHOWN_MAX)
                $display("%0t: result beat with nothing expected: kind %0d tx %02h qty %0d",
                         $time, got.kind, got.tx_byte, got.quantity);
            shown++;
            return;
        end
        want = expected_beats.pop_front();
        if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
            got.last !== want.last || got.quantity !== want.quantity ||
            got.value_bits !== want.value_bits || got.crc_ok !== want.crc_ok ||
            got.comm_error !== want.comm_error)
        begin
            fail_count++;
            if (shown < SHOWN_MAX)
            begin
                $display("%0t: mismatch expected kind %0d tx %02h last %0d qty %0d val %08h ok %0d err %0d",
                         $time, want.kind, want.tx_byte, want.last, want.quantity,
                         want.value_bits, want.crc_ok, want.comm_error);
                $display("%0t:          actual   kind %0d tx %02h last %0d qty %0d val %08h ok %0d err %0d",
                         $time, got.kind, got.tx_byte, got.last, got.quantity,
                         got.value_bits, got.crc_ok, got.comm_error);
            end
            shown++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr = 8'h01;
            reg_addr   = '{default: 16'h0000};
            rx_frame   = '{default: 8'h00};
            rx_count   = '0;
            qty_idx    = '0;
            prev_idx   = PREV_NONE;
            err_flag   = 1'b1;
            expected_beats.delete();
            fail_count    = 0;
            pending_count = 0;
            shown         = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_SLAVE_ADDRESS)
                    slave_addr = cfg.data[7:0];
                else if (cfg.index >= CFG_REG_ADDR_FIRST && cfg.index <= CFG_REG_ADDR_LAST)
                    reg_addr[cfg.index - CFG_REG_ADDR_FIRST] = cfg.data;
            end
            if (item.valid && item.ready)
            begin
                if (item.command == CMD_REQUEST)
                    predict_request();
                else
                    predict_rx(item.rx_byte);
            end
            if (result.valid && result.ready)
                check_result();
            pending_count = expected_beats.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the modbus rtu polling master: request and response beats
// in bursts, random back-pressure, config phases, verdict from the checker
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mrpm_pkg::*;
    import mrpm_tb_pkg::*;

    localparam int RANDOM_PHASES   = 4;
    localparam int ITEMS_PER_PHASE = 100;
    // longest quiet work of the block: ninth byte crc plus report post
    localparam int SETTLE_CYCLES   = 32;
    localparam int RESET_CYCLES    = 6;
    localparam int NO_SPLIT        = -1;

    localparam logic [7:0] SLAVE_ADDR_RESET = 8'h01;
    // byte count field of a read-input-registers answer with two registers
    localparam logic [7:0] RESP_DATA_LEN    = 8'd4;
    // index beyond the register map, must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_REG_ADDR_LAST + 1'b1;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mrpm_in_if  item_ch ();
    mrpm_out_if result_ch ();
    mrpm_cfg_if cfg_ch ();

    int fail_count;
    int pending_count;

    int         items_sent;
    int         burst_left;
    int         ready_hold;
    int         rx_phase;     // received bytes sent so far, modulo frame length
    logic [7:0] cur_slave;
    logic [15:0] addr_set [NUM_REG_ADDRS];

    modbus_rtu_polling_master dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    mrpm_poll_checker poll_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item_ch),
        .result        (result_ch),
        .cfg           (cfg_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always #6 clk = ~clk;

    // hard stop in case a handshake never completes
    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // result sink: short stalls, random toggling and long stall-free stretches
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    result_ch.ready <= 1'b0;
                    ready_hold = $urandom_range(1, 12);
                end
                3, 4:
                begin
                    result_ch.ready <= 1'b1;
                    ready_hold = $urandom_range(20, 60);
                end
                default:
                begin
                    result_ch.ready <= 1'($urandom_range(0, 1));
                    ready_hold = $urandom_range(0, 3);
                end
            endcase
        end
    end

    // one input beat; valid stays high between back-to-back beats of a burst
    task automatic send_item(input logic cmd, input logic [7:0] data);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        item_ch.valid   <= 1'b1;
        item_ch.command <= cmd;
        item_ch.rx_byte <= data;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        items_sent++;
        if (cmd == CMD_RX_BYTE)
            rx_phase = (rx_phase + 1) % RESPONSE_BYTES;
    endtask

    // stop sending, wait for every expected beat, then let the block go quiet
    task automatic settle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // full register set: slave address (junk in the upper bits), the six
    // register addresses from addr_set, and a write to the unmapped index
    task automatic program_meter(input logic [7:0] slave);
        write_reg(CFG_SLAVE_ADDRESS, {8'($urandom), slave});
        for (int q = 0; q < NUM_REG_ADDRS; q++)
            write_reg(CFG_IDX_W'(CFG_REG_ADDR_FIRST + q), addr_set[q]);
        write_reg(CFG_UNMAPPED, 16'($urandom));
        cur_slave = slave;
    endtask

    task automatic send_request();
        send_item(CMD_REQUEST, 8'($urandom));
    endtask

    // answer frame with a good crc, optionally one byte damaged and
    // optionally a request beat slipped in before byte split_at
    task automatic send_response(input logic [31:0] value, input logic corrupt,
                                 input int split_at);
        frame_bytes_t fr;
        logic [15:0]  crc;
        int           pos;
        fr[0] = cur_slave;
        fr[1] = FUNC_READ_INPUT;
        fr[2] = RESP_DATA_LEN;
        {fr[3], fr[4], fr[5], fr[6]} = value;
        crc = modbus_crc16(fr, RESPONSE_BYTES - 2);
        fr[7] = crc[7:0];
        fr[8] = crc[15:8];
        if (corrupt)
        begin
            pos = $urandom_range(0, RESPONSE_BYTES - 1);
            fr[pos] = fr[pos] ^ 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < RESPONSE_BYTES; i++)
        begin
            if (i == split_at)
                send_request();
            send_item(CMD_RX_BYTE, fr[i]);
        end
    endtask

    // random beats of either command
    task automatic send_noise(input int count);
        for (int i = 0; i < count; i++)
            send_item(1'($urandom_range(0, 1)), 8'($urandom));
    endtask

    // fill up a partly received frame so the next answer starts aligned
    task automatic align_frame();
        while (rx_phase != 0)
            send_item(CMD_RX_BYTE, 8'($urandom));
    endtask

    task automatic run_exchange();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
        begin
            // normal poll: request then its answer, sometimes damaged or split
            align_frame();
            send_request();
            send_response($urandom, $urandom_range(0, 5) == 0,
                          ($urandom_range(0, 9) == 0) ? $urandom_range(1, RESPONSE_BYTES - 1)
                                                      : NO_SPLIT);
        end
        else if (pick < 85)
        begin
            // unanswered request, the next one repeats the quantity
            send_request();
        end
        else if (pick < 95)
        begin
            send_noise($urandom_range(1, 12));
        end
        else
        begin
            // sender holds off until the block has drained
            settle();
        end
    endtask

    initial
    begin : stimulus
        int         target;
        logic [7:0] slave_pick;

        item_ch.valid   = 1'b0;
        item_ch.command = CMD_REQUEST;
        item_ch.rx_byte = 8'h00;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_SLAVE_ADDRESS;
        cfg_ch.data     = 16'h0000;
        result_ch.ready = 1'b0;
        burst_left      = 0;
        ready_hold      = 0;
        items_sent      = 0;
        rx_phase        = 0;
        cur_slave       = SLAVE_ADDR_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part on reset settings
        send_request();                             // first request, no error
        send_request();                             // same quantity again sets the error
        send_response(32'hFFFF_FFFF, 1'b0, 4);      // request slipped into a frame, good crc
        send_request();                             // next quantity after a good answer
        send_response(32'h0000_0000, 1'b1, NO_SPLIT); // damaged frame, crc mismatch
        settle();

        // random phases, each on its own register setting, extremes first
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    slave_pick = 8'h00;
                    addr_set   = '{default: 16'h0000};
                end
                1:
                begin
                    slave_pick = 8'hFF;
                    addr_set   = '{default: 16'hFFFF};
                end
                default:
                begin
                    slave_pick = 8'($urandom);
                    foreach (addr_set[q])
                        addr_set[q] = 16'($urandom);
                end
            endcase
            program_meter(slave_pick);
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
                run_exchange();
            settle();
        end

        if (fail_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
sv/mrpm_pkg.sv
sv/mrpm_if.sv
sv/mrpm_crc_unit.sv
sv/modbus_rtu_polling_master.sv
tb/mrpm_tb_pkg.sv
tb/mrpm_poll_checker.sv
tb/tb_top.sv
